>>> rtl/core/icvd_pkg.sv
// Package for the interlaced chroma vertical downsampler.
// Holds the row phase type and fixed register constants; no dependencies.
package icvd_pkg;

  // Width and reset value of the row width register
  localparam int unsigned CfgWidthBits = 11;
  localparam logic [CfgWidthBits-1:0] RowWidthReset = 11'd960;

  // Row position within a group of four rows
  typedef enum logic [1:0] {
    PH_EVEN_STORE = 2'd0,  // row 0: store into even line buffer
    PH_ODD_STORE  = 2'd1,  // row 1: store into odd line buffer
    PH_TOP_OUT    = 2'd2,  // row 2: top field output
    PH_BOT_OUT    = 2'd3   // row 3: bottom field output
  } row_phase_e;

endpackage

>>> rtl/core/icvd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while the read enable is low. No dependencies.
module icvd_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/interlaced_chroma_vertical_downsample_unit.sv
// Pipeline: an accepted input item passes the line buffer read register, then
// the output register. Throughput: 1 item per cycle unless the output stalls,
// set by the single line buffer access each item makes; rows 0/1 give no output.
// Reset (rst_ni low, async): row width 960, column and row phase cleared,
// pipeline emptied. Line buffers are not cleared; no clearing pass.
// Depends on icvd_pkg and icvd_ram.
module interlaced_chroma_vertical_downsample_unit #(
  parameter int unsigned LINE_MAX    = 1024,
  parameter int unsigned SAMPLE_BITS = 10,
  localparam int unsigned TdataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration: row width
  input  logic                                   cfg_we_i,
  input  logic [icvd_pkg::CfgWidthBits-1:0]      cfg_wdata_i,
  // Input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [TdataW-1:0]                      s_axis_tdata,  // sample_value, zero pad
  input  logic                                   s_axis_tuser,  // plane_start
  // Output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [TdataW-1:0]                      m_axis_tdata,  // out_sample, zero pad
  output logic                                   m_axis_tuser,  // bottom_field
  output logic                                   m_axis_tlast   // row_end
);

  localparam int unsigned AddrW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int unsigned ColW  = $clog2(LINE_MAX + 1);
  localparam int unsigned CmpW  =
    ((ColW > icvd_pkg::CfgWidthBits) ? ColW : icvd_pkg::CfgWidthBits) + 1;
  localparam int unsigned SumW  = SAMPLE_BITS + 2;

  // Configuration register
  logic [icvd_pkg::CfgWidthBits-1:0] row_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= icvd_pkg::RowWidthReset;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  // Effective width: zero acts as one, clamped to the line length
  logic [CmpW-1:0] eff_width;

  always_comb begin
    eff_width = CmpW'(row_width_q);
    if (row_width_q == '0) begin
      eff_width = CmpW'(1);
    end else if (CmpW'(row_width_q) > CmpW'(LINE_MAX)) begin
      eff_width = CmpW'(LINE_MAX);
    end
  end

  // Position state
  logic [ColW-1:0]          col_q, col_d;
  icvd_pkg::row_phase_e     phase_q, phase_d;

  // Pipeline state
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_bottom_q;
  logic                     s1_last_q;
  logic [SAMPLE_BITS-1:0]   s1_sample_q;
  logic                     m_valid_q, m_valid_d;
  logic [SAMPLE_BITS-1:0]   m_data_q;
  logic                     m_bottom_q;
  logic                     m_last_q;

  logic                     accept;
  logic                     s1_adv;
  logic [ColW-1:0]          col_cur;
  icvd_pkg::row_phase_e     phase_cur;
  logic                     row_last;
  logic [AddrW-1:0]         col_idx;
  logic [SAMPLE_BITS-1:0]   in_sample;
  logic                     we_even, we_odd, re_even, re_odd;
  logic [SAMPLE_BITS-1:0]   even_rdata, odd_rdata;

  // Handshake: output register frees stage 1, stage 1 frees the input
  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];

  // Column and phase for the incoming item; plane start clears both
  always_comb begin
    col_cur   = s_axis_tuser ? '0 : col_q;
    phase_cur = s_axis_tuser ? icvd_pkg::PH_EVEN_STORE : phase_q;
    row_last  = (CmpW'(col_cur) + CmpW'(1)) >= eff_width;
    if (col_cur >= ColW'(LINE_MAX - 1)) begin
      col_idx = AddrW'(LINE_MAX - 1);
    end else begin
      col_idx = col_cur[AddrW-1:0];
    end
  end

  // Line buffer accesses, one per item
  always_comb begin
    we_even = 1'b0;
    we_odd  = 1'b0;
    re_even = 1'b0;
    re_odd  = 1'b0;
    case (phase_cur)
      icvd_pkg::PH_EVEN_STORE: we_even = accept;
      icvd_pkg::PH_ODD_STORE:  we_odd  = accept;
      icvd_pkg::PH_TOP_OUT:    re_even = accept;
      icvd_pkg::PH_BOT_OUT:    re_odd  = accept;
      default: ;
    endcase
  end

  // Next position
  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    if (accept) begin
      if (row_last) begin
        col_d   = '0;
        phase_d = icvd_pkg::row_phase_e'(2'(phase_cur + 2'd1));
      end else begin
        col_d   = ColW'(col_idx) + ColW'(1);
        phase_d = phase_cur;
      end
    end
  end

  // Pipeline valid flow
  always_comb begin
    if (accept) begin
      s1_valid_d = re_even || re_odd;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    m_valid_d = s1_adv ? s1_valid_q : m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      phase_q    <= icvd_pkg::PH_EVEN_STORE;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      phase_q    <= phase_d;
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Line buffers: rows 0 and 1 of the group
  icvd_ram #(
    .Width (SAMPLE_BITS),
    .Depth (LINE_MAX)
  ) u_line_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (col_idx),
    .wdata_i (in_sample),
    .re_i    (re_even),
    .raddr_i (col_idx),
    .rdata_o (even_rdata)
  );

  icvd_ram #(
    .Width (SAMPLE_BITS),
    .Depth (LINE_MAX)
  ) u_line_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (col_idx),
    .wdata_i (in_sample),
    .re_i    (re_odd),
    .raddr_i (col_idx),
    .rdata_o (odd_rdata)
  );

  // Weighted average: 3x the row nearer the output field plus the other, rounded
  logic [SAMPLE_BITS-1:0] heavy, light;
  logic [SumW-1:0]        wsum;

  always_comb begin
    heavy = s1_bottom_q ? s1_sample_q : even_rdata;
    light = s1_bottom_q ? odd_rdata : s1_sample_q;
    wsum  = (SumW'(heavy) << 1) + SumW'(heavy) + SumW'(light) + SumW'(2);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bottom_q <= (phase_cur == icvd_pkg::PH_BOT_OUT);
      s1_last_q   <= row_last;
      s1_sample_q <= in_sample;
    end
    if (s1_valid_q && s1_adv) begin
      m_data_q   <= wsum[SumW-1:2];
      m_bottom_q <= s1_bottom_q;
      m_last_q   <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TdataW'(m_data_q);
  assign m_axis_tuser  = m_bottom_q;
  assign m_axis_tlast  = m_last_q;

endmodule

>>> rtl/core/icvd_checker.sv
// Port-level checker for the interlaced chroma vertical downsampler,
// bound to the top level. Depends on the top level's port list.
module icvd_checker #(
  parameter int unsigned SAMPLE_BITS = 10,
  localparam int unsigned TdataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_valid_i,
  input logic              s_ready_i,
  input logic              m_valid_i,
  input logic              m_ready_i,
  input logic [TdataW-1:0] m_data_i,
  input logic              m_user_i,
  input logic              m_last_i
);

  // A stalled result item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i)
      && $stable(m_user_i) && $stable(m_last_i))
    else $error("stalled output item changed");

  // With the output register empty, the input side is never blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_valid_i |-> s_ready_i)
    else $error("input stalled while output empty");

  // A fresh output item follows an accepted input item through stage 1 and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_i) |-> $past(s_valid_i && s_ready_i, 2))
    else $error("output item without matching input item");

  // Result values stay in sample range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> (m_data_i >> SAMPLE_BITS) == '0)
    else $error("output sample out of range");

endmodule

bind interlaced_chroma_vertical_downsample_unit icvd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_icvd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid),
  .s_ready_i (s_axis_tready),
  .m_valid_i (m_axis_tvalid),
  .m_ready_i (m_axis_tready),
  .m_data_i  (m_axis_tdata),
  .m_user_i  (m_axis_tuser),
  .m_last_i  (m_axis_tlast)
);

>>> sim/interlaced_chroma_vertical_downsample_unit_tb.sv
// Self-checking testbench for the interlaced chroma vertical downsampler.
// Drives sample streams with random gaps and stalls, predicts each output item.
// Depends on icvd_pkg and the interlaced_chroma_vertical_downsample_unit RTL.
`timescale 1ns / 100ps

module interlaced_chroma_vertical_downsample_unit_tb;

  localparam int unsigned LineMax      = 1024;
  localparam int unsigned SampleBits   = 10;
  localparam int unsigned TdataW       = 16;
  localparam int unsigned CfgWidthBits = icvd_pkg::CfgWidthBits;
  localparam int unsigned DrainCycles  = 6;

  // One downsampled output item
  typedef struct packed {
    logic [SampleBits-1:0] value;
    logic                  bottom;
    logic                  row_end;
  } chroma_out_t;

  // One line of the directed stimulus
  typedef struct packed {
    logic                    set_width;
    logic [CfgWidthBits-1:0] width;
    logic [SampleBits-1:0]   sample;
    logic                    plane;
    logic                    given;      // expected item typed in below
    logic                    given_out;  // typed-in row produces an item
    chroma_out_t             result;
  } probe_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgWidthBits-1:0] cfg_wdata_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [TdataW-1:0]       s_axis_tdata;   // sample_value, zero pad
  logic                    s_axis_tuser;   // plane_start
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [TdataW-1:0]       m_axis_tdata;   // out_sample, zero pad
  logic                    m_axis_tuser;   // bottom_field
  logic                    m_axis_tlast;   // row_end

  // Predictor state
  logic [CfgWidthBits-1:0] width_reg;
  logic [SampleBits-1:0]   even_line [LineMax];
  logic [SampleBits-1:0]   odd_line  [LineMax];
  bit                      even_seen [LineMax];
  bit                      odd_seen  [LineMax];
  int unsigned             col_q;
  icvd_pkg::row_phase_e    phase_q;

  chroma_out_t pending_out [$];
  int unsigned mismatch_count;
  int unsigned tx_gap_max;
  int unsigned rx_stall_max;
  bit          fresh_plane_needed;

  // Directed items; typed-in expectations only where obvious
  probe_row_t probe_rows [25] = '{
    // width 0 acts as 1: every item is a whole row
    '{1'b1, 11'd0, 10'd1023, 1'b1, 1'b1, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd1023, 1'b0, 1'b1, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd1023, 1'b0, 1'b1, 1'b1, '{10'd1023, 1'b0, 1'b1}},
    '{1'b0, 11'd0, 10'd1023, 1'b0, 1'b1, 1'b1, '{10'd1023, 1'b1, 1'b1}},
    '{1'b0, 11'd0, 10'd0,    1'b0, 1'b1, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd0,    1'b0, 1'b1, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd0,    1'b0, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b1}},
    '{1'b0, 11'd0, 10'd0,    1'b0, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b1}},
    '{1'b0, 11'd0, 10'd1023, 1'b0, 1'b1, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd0,    1'b0, 1'b1, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd0,    1'b0, 1'b1, 1'b1, '{10'd767, 1'b0, 1'b1}},
    '{1'b0, 11'd0, 10'd1023, 1'b0, 1'b1, 1'b1, '{10'd767, 1'b1, 1'b1}},
    // repeated plane start, then plane start landing on a bottom row
    '{1'b0, 11'd0, 10'd5,    1'b1, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd1,    1'b1, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd2,    1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd7,    1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd9,    1'b1, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    // width 3, then shrink to 1 while column 2 of row 1 is next
    '{1'b1, 11'd3, 10'd100,  1'b1, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd200,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd300,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd400,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd500,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b1, 11'd1, 10'd600,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd700,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0, 10'd800,  1'b0, 1'b0, 1'b0, '{10'd0, 1'b0, 1'b0}}
  };

  interlaced_chroma_vertical_downsample_unit #(
    .LINE_MAX   (LineMax),
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("** interlaced_chroma_vertical_downsample_unit: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Width in use: zero acts as one, clamp to line buffer size
  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > LineMax) return LineMax;
    return width_reg;
  endfunction

  // Advance the predictor by one sample; returns 1 when an item comes out
  function automatic bit predict_chroma(input logic [SampleBits-1:0] s, input logic plane,
                                        output chroma_out_t res);
    int unsigned w;
    int unsigned col;
    int unsigned acc;
    bit          at_end;
    bit          made;
    w = active_width();
    if (plane) begin
      col_q   = 0;
      phase_q = icvd_pkg::PH_EVEN_STORE;
    end
    col    = col_q;
    at_end = (col + 1 >= w);
    made   = 1'b0;
    res    = '0;
    case (phase_q)
      icvd_pkg::PH_EVEN_STORE: begin
        even_line[col] = s;
        even_seen[col] = 1'b1;
      end
      icvd_pkg::PH_ODD_STORE: begin
        odd_line[col] = s;
        odd_seen[col] = 1'b1;
      end
      icvd_pkg::PH_TOP_OUT: begin
        acc         = (3 * even_line[col] + s + 2) >> 2;
        res.value   = acc[SampleBits-1:0];
        res.bottom  = 1'b0;
        res.row_end = at_end;
        made        = 1'b1;
      end
      default: begin
        acc         = (odd_line[col] + 3 * s + 2) >> 2;
        res.value   = acc[SampleBits-1:0];
        res.bottom  = 1'b1;
        res.row_end = at_end;
        made        = 1'b1;
      end
    endcase
    if (at_end) begin
      col_q   = 0;
      phase_q = phase_q.next();
    end else begin
      col_q = col + 1;
    end
    return made;
  endfunction

  // Mostly random samples, with the extremes more often
  function automatic logic [SampleBits-1:0] draw_chroma();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SampleBits'($urandom_range(0, 1023));
    endcase
  endfunction

  // Send one item after a random gap; called at a rising edge
  task automatic send_sample(input logic [SampleBits-1:0] s, input logic plane,
                             input bit use_given = 1'b0, input bit given_out = 1'b0,
                             input chroma_out_t given_res = '0);
    int unsigned gap;
    logic        plane_bit;
    chroma_out_t res;
    bit          made;
    gap       = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    plane_bit = plane | fresh_plane_needed;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataW'(s);
    s_axis_tuser  <= plane_bit;
    do @(posedge clk_i); while (!s_axis_tready);
    fresh_plane_needed = 1'b0;
    made = predict_chroma(s, plane_bit, res);
    if (use_given) begin
      made = given_out;
      res  = given_res;
    end
    if (made) pending_out.push_back(res);
  endtask

  // Full rows at the current width, plane start on the first sample
  task automatic send_rows(input int unsigned rows);
    int unsigned n;
    n = rows * active_width();
    for (int unsigned i = 0; i < n; i++) send_sample(draw_chroma(), i == 0);
  endtask

  // Write the row width once the block has gone quiet
  task automatic write_row_width(input logic [CfgWidthBits-1:0] w);
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    width_reg = w;
    // a wider row must not read line buffer entries that were never filled
    for (int unsigned i = 0; i < active_width(); i++) begin
      if (!even_seen[i] || !odd_seen[i]) fresh_plane_needed = 1'b1;
    end
  endtask

  // Output side: random stall before each item
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each output item with the oldest prediction
  always @(posedge clk_i) begin
    chroma_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected item: sample %0d bottom %0b row_end %0b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata !== TdataW'(want.value))
          report_mismatch($sformatf("out_sample %0d, want %0d", m_axis_tdata, want.value));
        if (m_axis_tuser !== want.bottom)
          report_mismatch($sformatf("bottom_field %0b, want %0b", m_axis_tuser, want.bottom));
        if (m_axis_tlast !== want.row_end)
          report_mismatch($sformatf("row_end %0b, want %0b", m_axis_tlast, want.row_end));
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned random_count;
    int unsigned n;
    int unsigned w;
    logic [CfgWidthBits-1:0] new_width;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    mismatch_count     = 0;
    random_count       = 0;
    fresh_plane_needed = 1'b0;
    tx_gap_max         = 14;
    rx_stall_max       = 14;
    width_reg          = icvd_pkg::RowWidthReset;
    col_q              = 0;
    phase_q            = icvd_pkg::PH_EVEN_STORE;
    foreach (even_line[i]) begin
      even_line[i] = '0;
      odd_line[i]  = '0;
      even_seen[i] = 1'b0;
      odd_seen[i]  = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].set_width) write_row_width(probe_rows[i].width);
      send_sample(probe_rows[i].sample, probe_rows[i].plane, probe_rows[i].given,
                  probe_rows[i].given_out, probe_rows[i].result);
    end

    // Full rows at width 12, back to back
    write_row_width(11'd12);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    send_rows(8);

    // Random phases: new width, then planes or noise
    while (random_count < 1000) begin
      case ($urandom_range(0, 15))
        0:       new_width = '0;
        1:       new_width = CfgWidthBits'($urandom_range(1024, 2047));
        2:       new_width = 11'd1;
        default: new_width = CfgWidthBits'($urandom_range(2, 12));
      endcase
      write_row_width(new_width);
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 14;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      w = active_width();
      if (w > 16 || $urandom_range(0, 3) == 0) begin
        // noise: random plane starts, rows cut anywhere
        n = $urandom_range(4, 40);
        repeat (n) begin
          send_sample(draw_chroma(), $urandom_range(0, 15) == 0);
          random_count++;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          n = w * 4 * $urandom_range(1, 3);
          if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);  // truncated plane
          for (int unsigned i = 0; i < n; i++) begin
            send_sample(draw_chroma(), i == 0);
            random_count++;
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** interlaced_chroma_vertical_downsample_unit: PASSED **");
    end else begin
      $display("** interlaced_chroma_vertical_downsample_unit: FAILED **");
    end
    $finish;
  end

endmodule
